### sv/agm_pkg.sv
// ----------------------------------------------------------------------------
// agm_pkg
// Shared constants and types of the audio gain and level meter: field widths,
// frame length limit, divider and root sizes, and the queue entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package agm_pkg;

  localparam int MAX_FRAME_SAMPLES = 1024;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int PROD_W   = MAG_W + GAIN_W;
  localparam int SQ_W     = 2 * SAMPLE_W;
  localparam int CNT_W    = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int ACC_W    = 41;
  localparam int PEAK_W   = 16;
  localparam int RMS_W    = 16;
  localparam int SEQ_W    = 32;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // restoring divider and bit-pair square root
  localparam int DIV_STEPS  = ACC_W;
  localparam int SQRT_W     = ACC_W + (ACC_W % 2);
  localparam int SQRT_STEPS = SQRT_W / 2;
  localparam int SREM_W     = SQRT_STEPS + 4;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_GAIN_Q8_8 = 1'b0;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_done;
    logic [CNT_W-1:0]    samples;
    logic [ACC_W-1:0]    sum;
    logic [PEAK_W-1:0]   peak;
    logic [SEQ_W-1:0]    frame_no;
  } agm_entry_t;

endpackage

`default_nettype wire

### sv/agm_front.sv
// ----------------------------------------------------------------------------
// agm_front
// Takes one sample at a time, applies the Q8.8 gain with saturation, squares
// the result and updates the frame statistics, then pushes a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module agm_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [agm_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  wire logic                                 in_frame_end,
  input  wire logic        [agm_pkg::GAIN_W-1:0]    gain,
  input  wire logic                                 q_full,
  output logic                                      push,
  output agm_pkg::agm_entry_t                       push_entry
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_SQ, F_ACC} fstate_t;

  fstate_t                          state_r;
  logic                             neg_r;
  logic                             fe_r;
  logic [agm_pkg::MAG_W-1:0]        mag_in_r;
  logic [agm_pkg::PROD_W-1:0]       prod_r;
  logic [agm_pkg::SAMPLE_W-1:0]     mag_r;
  logic [agm_pkg::SQ_W-1:0]         sq_r;
  logic [agm_pkg::ACC_W-1:0]        acc_r;
  logic [agm_pkg::PEAK_W-1:0]       peak_r;
  logic [agm_pkg::CNT_W-1:0]        cnt_r;
  logic [agm_pkg::SEQ_W-1:0]        seq_r;

  logic [agm_pkg::SAMPLE_W-1:0]     raw;
  logic                             raw_neg;
  logic [agm_pkg::MAG_W-1:0]        mag_in;
  logic [agm_pkg::PROD_W-9:0]       shifted;
  logic [agm_pkg::PROD_W-9:0]       limit;
  logic [agm_pkg::SAMPLE_W-1:0]     sat_mag;
  logic [agm_pkg::ACC_W:0]          sum_ext;
  logic [agm_pkg::ACC_W-1:0]        acc_nxt;
  logic [agm_pkg::PEAK_W-1:0]       peak_nxt;
  logic [agm_pkg::CNT_W-1:0]        cnt_nxt;
  logic                             done;
  logic [agm_pkg::SAMPLE_W-1:0]     sample_bits;

  assign raw     = $unsigned(in_sample_in);
  assign raw_neg = raw[agm_pkg::SAMPLE_W-1];
  assign mag_in  = raw_neg ? (agm_pkg::MAG_W'(1 << agm_pkg::SAMPLE_W) - {1'b0, raw})
                           : {1'b0, raw};

  // truncate toward zero, then clamp to the signed range
  assign shifted = prod_r[agm_pkg::PROD_W-1:8];
  assign limit   = neg_r ? (agm_pkg::PROD_W-8)'(32768) : (agm_pkg::PROD_W-8)'(32767);
  assign sat_mag = (shifted > limit) ? limit[agm_pkg::SAMPLE_W-1:0]
                                     : shifted[agm_pkg::SAMPLE_W-1:0];

  assign sample_bits = neg_r ? (agm_pkg::SAMPLE_W'(0) - mag_r) : mag_r;
  assign sum_ext     = {1'b0, acc_r} + (agm_pkg::ACC_W+1)'(sq_r);
  assign acc_nxt     = sum_ext[agm_pkg::ACC_W] ? agm_pkg::ACC_MAX
                                               : sum_ext[agm_pkg::ACC_W-1:0];
  assign peak_nxt    = (agm_pkg::PEAK_W'(mag_r) > peak_r) ? agm_pkg::PEAK_W'(mag_r) : peak_r;
  assign cnt_nxt     = cnt_r + agm_pkg::CNT_W'(1);
  assign done        = fe_r || (cnt_nxt >= agm_pkg::CNT_W'(agm_pkg::MAX_FRAME_SAMPLES));

  assign in_stall = (state_r != F_IDLE);
  assign push     = (state_r == F_ACC) && !q_full;

  always_comb begin
    push_entry            = '0;
    push_entry.sample     = sample_bits;
    if (done) begin
      push_entry.frame_done = 1'b1;
      push_entry.samples    = cnt_nxt;
      push_entry.sum        = acc_nxt;
      push_entry.peak       = peak_nxt;
      push_entry.frame_no   = seq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      acc_r   <= '0;
      peak_r  <= '0;
      cnt_r   <= '0;
      seq_r   <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            neg_r    <= raw_neg;
            fe_r     <= in_frame_end;
            mag_in_r <= mag_in;
            state_r  <= F_MUL;
          end
        end
        F_MUL: begin
          prod_r  <= agm_pkg::PROD_W'(mag_in_r) * agm_pkg::PROD_W'(gain);
          state_r <= F_SQ;
        end
        F_SQ: begin
          mag_r   <= sat_mag;
          sq_r    <= agm_pkg::SQ_W'(sat_mag) * agm_pkg::SQ_W'(sat_mag);
          state_r <= F_ACC;
        end
        F_ACC: begin
          if (!q_full) begin
            if (done) begin
              acc_r  <= '0;
              peak_r <= '0;
              cnt_r  <= '0;
              seq_r  <= seq_r + agm_pkg::SEQ_W'(1);
            end else begin
              acc_r  <= acc_nxt;
              peak_r <= peak_nxt;
              cnt_r  <= cnt_nxt;
            end
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_entry.frame_done |=> (cnt_r == '0) && (acc_r == '0))
    else $error("frame statistics not cleared after frame end");

endmodule

`default_nettype wire

### sv/agm_queue.sv
// ----------------------------------------------------------------------------
// agm_queue
// Short register queue between the per-sample front and the frame back end.
// ----------------------------------------------------------------------------
`default_nettype none

module agm_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire agm_pkg::agm_entry_t  push_entry,
  output logic                      full,
  input  wire logic                 pop,
  output agm_pkg::agm_entry_t       pop_entry,
  output logic                      empty
);

  agm_pkg::agm_entry_t            entries_r [agm_pkg::QUEUE_DEPTH];
  logic [agm_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [agm_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [agm_pkg::QPTR_W:0]       count_r;

  function automatic logic [agm_pkg::QPTR_W-1:0] ptr_inc(input logic [agm_pkg::QPTR_W-1:0] p);
    return (p == agm_pkg::QPTR_W'(agm_pkg::QUEUE_DEPTH - 1)) ? '0 : p + agm_pkg::QPTR_W'(1);
  endfunction

  assign full      = (count_r == (agm_pkg::QPTR_W+1)'(agm_pkg::QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign pop_entry = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + (agm_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (agm_pkg::QPTR_W+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

### sv/agm_back.sv
// ----------------------------------------------------------------------------
// agm_back
// Drains the queue into the output register; on a frame end it divides the
// sum of squares by the count and takes the integer square root first.
// ----------------------------------------------------------------------------
`default_nettype none

module agm_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire agm_pkg::agm_entry_t                  pop_entry,
  input  wire logic                                 empty,
  output logic                                      pop,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [agm_pkg::SAMPLE_W-1:0]       out_sample_out,
  output logic                                      out_frame_done,
  output logic        [agm_pkg::CNT_W-1:0]          out_frame_samples,
  output logic        [agm_pkg::ACC_W-1:0]          out_sum_of_squares,
  output logic        [agm_pkg::PEAK_W-1:0]         out_peak_level,
  output logic        [agm_pkg::RMS_W-1:0]          out_rms_level,
  output logic        [agm_pkg::SEQ_W-1:0]          out_frame_number
);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_SQRT, B_LOAD} bstate_t;

  bstate_t                              state_r;
  agm_pkg::agm_entry_t                  ent_r;
  agm_pkg::agm_entry_t                  out_ent_r;
  logic [agm_pkg::RMS_W-1:0]            out_rms_r;
  logic                                 out_valid_r;
  logic [agm_pkg::STEP_W-1:0]           step_r;
  logic [agm_pkg::ACC_W-1:0]            dvd_r;
  logic [agm_pkg::CNT_W:0]              rem_r;
  logic [agm_pkg::SQRT_W-1:0]           rad_r;
  logic [agm_pkg::SREM_W-1:0]           srem_r;
  logic [agm_pkg::SQRT_STEPS-1:0]       root_r;

  logic                                 out_free;
  logic                                 out_load;
  logic                                 out_valid_nxt;
  logic [agm_pkg::CNT_W:0]              div_sh;
  logic [agm_pkg::CNT_W+1:0]            div_diff;
  logic                                 div_ge;
  logic [agm_pkg::CNT_W:0]              rem_nxt;
  logic [agm_pkg::ACC_W-1:0]            dvd_nxt;
  logic [agm_pkg::SREM_W-1:0]           srem_sh;
  logic [agm_pkg::SREM_W-1:0]           trial;
  logic                                 sq_ge;
  logic [agm_pkg::SREM_W-1:0]           srem_nxt;
  logic [agm_pkg::SQRT_STEPS-1:0]       root_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (state_r == B_IDLE) && !empty && (pop_entry.frame_done || out_free);

  // output register load and hold
  assign out_load      = (pop && !pop_entry.frame_done) || ((state_r == B_LOAD) && out_free);
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  // one quotient bit a cycle
  assign div_sh   = {rem_r[agm_pkg::CNT_W-1:0], dvd_r[agm_pkg::ACC_W-1]};
  assign div_diff = {1'b0, div_sh} - (agm_pkg::CNT_W+2)'(ent_r.samples);
  assign div_ge   = !div_diff[agm_pkg::CNT_W+1];
  assign rem_nxt  = div_ge ? div_diff[agm_pkg::CNT_W:0] : div_sh;
  assign dvd_nxt  = {dvd_r[agm_pkg::ACC_W-2:0], div_ge};

  // one root bit a cycle
  assign srem_sh  = {srem_r[agm_pkg::SREM_W-3:0], rad_r[agm_pkg::SQRT_W-1 -: 2]};
  assign trial    = agm_pkg::SREM_W'({root_r, 2'b01});
  assign sq_ge    = (srem_sh >= trial);
  assign srem_nxt = sq_ge ? (srem_sh - trial) : srem_sh;
  assign root_nxt = {root_r[agm_pkg::SQRT_STEPS-2:0], sq_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        B_IDLE: begin
          if (pop) begin
            if (pop_entry.frame_done) begin
              ent_r   <= pop_entry;
              dvd_r   <= pop_entry.sum;
              rem_r   <= '0;
              step_r  <= '0;
              state_r <= B_DIV;
            end else begin
              out_ent_r <= pop_entry;
              out_rms_r <= '0;
            end
          end
        end
        B_DIV: begin
          dvd_r  <= dvd_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + agm_pkg::STEP_W'(1);
          if (step_r == agm_pkg::STEP_W'(agm_pkg::DIV_STEPS - 1)) begin
            rad_r   <= agm_pkg::SQRT_W'(dvd_nxt);
            srem_r  <= '0;
            root_r  <= '0;
            step_r  <= '0;
            state_r <= B_SQRT;
          end
        end
        B_SQRT: begin
          rad_r  <= {rad_r[agm_pkg::SQRT_W-3:0], 2'b00};
          srem_r <= srem_nxt;
          root_r <= root_nxt;
          step_r <= step_r + agm_pkg::STEP_W'(1);
          if (step_r == agm_pkg::STEP_W'(agm_pkg::SQRT_STEPS - 1)) begin
            state_r <= B_LOAD;
          end
        end
        B_LOAD: begin
          if (out_free) begin
            out_ent_r <= ent_r;
            out_rms_r <= root_r[agm_pkg::RMS_W-1:0];
            state_r   <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample_out     = $signed(out_ent_r.sample);
  assign out_frame_done     = out_ent_r.frame_done;
  assign out_frame_samples  = out_ent_r.samples;
  assign out_sum_of_squares = out_ent_r.sum;
  assign out_peak_level     = out_ent_r.peak;
  assign out_rms_level      = out_rms_r;
  assign out_frame_number   = out_ent_r.frame_no;

  a_done_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ent_r.frame_done |-> out_ent_r.samples != '0)
    else $error("frame result with zero sample count");

  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_LOAD |-> root_r[agm_pkg::SQRT_STEPS-1:agm_pkg::RMS_W] == '0)
    else $error("rms root exceeds output width");

  a_plain_passes: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !pop_entry.frame_done |=> out_valid_r)
    else $error("plain sample not moved to output");

endmodule

`default_nettype wire

### sv/audio_gain_level_meter_core.sv
// ----------------------------------------------------------------------------
// audio_gain_level_meter_core
// Digital Q8.8 gain with per-frame sum of squares, peak, count and RMS meter.
// ----------------------------------------------------------------------------
// path: a sample passes the front states (idle, multiply, square, accumulate),
//   the queue and the output register; a frame end adds a 41-step divider
//   and a 21-step square root; the front takes a new request only in idle,
//   and a 2-entry queue lets samples continue behind a frame end
// reset: gain returns to unity (256), frame statistics and sequence clear
`default_nettype none

module audio_gain_level_meter_core (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [agm_pkg::SAMPLE_W-1:0]     in_sample_in,
  input  wire logic                                    in_frame_end,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [agm_pkg::SAMPLE_W-1:0]          out_sample_out,
  output logic                                         out_frame_done,
  output logic        [agm_pkg::CNT_W-1:0]             out_frame_samples,
  output logic        [agm_pkg::ACC_W-1:0]             out_sum_of_squares,
  output logic        [agm_pkg::PEAK_W-1:0]            out_peak_level,
  output logic        [agm_pkg::RMS_W-1:0]             out_rms_level,
  output logic        [agm_pkg::SEQ_W-1:0]             out_frame_number,
  input  wire logic                                    psel,
  input  wire logic                                    penable,
  input  wire logic                                    pwrite,
  input  wire logic   [agm_pkg::CFG_ADDR_W-1:0]        paddr,
  input  wire logic   [agm_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic        [agm_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                         pready
);

  logic [agm_pkg::GAIN_W-1:0] gain_r;
  logic                       cfg_hit;
  logic                       q_full;
  logic                       q_empty;
  logic                       push;
  logic                       pop;
  agm_pkg::agm_entry_t        push_entry;
  agm_pkg::agm_entry_t        pop_entry;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[agm_pkg::CFG_ADDR_W-1] == agm_pkg::REG_GAIN_Q8_8);
  assign prdata  = cfg_hit ? agm_pkg::CFG_DATA_W'(gain_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= agm_pkg::GAIN_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      gain_r <= pwdata[agm_pkg::GAIN_W-1:0];
    end
  end

  agm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_in (in_sample_in),
    .in_frame_end (in_frame_end),
    .gain         (gain_r),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  agm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  agm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_entry          (pop_entry),
    .empty              (q_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample_out     (out_sample_out),
    .out_frame_done     (out_frame_done),
    .out_frame_samples  (out_frame_samples),
    .out_sum_of_squares (out_sum_of_squares),
    .out_peak_level     (out_peak_level),
    .out_rms_level      (out_rms_level),
    .out_frame_number   (out_frame_number)
  );

endmodule

`default_nettype wire
